// ----- src/nearest_obstacle_speed_limiter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Nearest obstacle speed limiter: assertion macros
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef NEAREST_OBSTACLE_SPEED_LIMITER_UNIT_MACROS_SVH
`define NEAREST_OBSTACLE_SPEED_LIMITER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NOSL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nosl check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define NOSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nosl check failed in the next cycle");

`endif

// ----- src/nosl_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest obstacle speed limiter package
// Widths, register indexes, reset values and the word types between stages.
// ----------------------------------------------------------------------------
package nosl_pkg;

   // Default detection range in mm.
   localparam int MAX_RANGE_MM_DEF = 8000;
   // Points nearer than this are ignored, mm.
   localparam int MIN_DIST_MM = 100;

   localparam int COORD_W   = 16;
   localparam int BUF_W     = 15;
   localparam int GAIN_W    = 20;
   localparam int SPEED_W   = 16;
   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 3;

   // Depths of the scan queue and the result queue.
   localparam int SCAN_Q_DEPTH_DEF = 2;
   localparam int RSP_Q_DEPTH_DEF  = 2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_MIN_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_MAX_X  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REV_MIN_X  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REV_MAX_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAR_BUFFER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_GAIN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REV_GAIN   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE     = 3'd7;

   // Register reset values.
   localparam logic signed [COORD_W-1:0] RST_WIN_MIN_X  = -16'sd300;
   localparam logic signed [COORD_W-1:0] RST_WIN_MAX_X  = 16'sd300;
   localparam logic [BUF_W-1:0]          RST_CAR_BUFFER = 15'd500;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic signed [COORD_W-1:0] fwd_min_x;
      logic signed [COORD_W-1:0] fwd_max_x;
      logic signed [COORD_W-1:0] rev_min_x;
      logic signed [COORD_W-1:0] rev_max_x;
      logic [BUF_W-1:0]          car_buffer_mm;
      logic [GAIN_W-1:0]         fwd_gain;
      logic [GAIN_W-1:0]         rev_gain;
      logic [BUF_W-1:0]          cruise_speed;
   } nosl_cfg_type;

   // One finished scan, handed from the front to the back.
   typedef struct packed {
      logic signed [COORD_W-1:0] nearest_x;
      logic signed [COORD_W-1:0] nearest_y;
      logic                      found;
      logic                      rev;
   } nosl_scan_type;

   // One result word.
   typedef struct packed {
      logic signed [COORD_W-1:0] nearest_x;
      logic signed [COORD_W-1:0] nearest_y;
      logic                      found;
      logic signed [SPEED_W-1:0] speed;
   } nosl_rsp_type;

   // Status of the scan in progress.
   typedef struct packed {
      logic found;
      logic rev;
   } nosl_front_status_type;

endpackage

// ----- src/nearest_obstacle_speed_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// Nearest obstacle speed limiter unit
// Scan points go in through a queue-like port (push/full); each point is
// windowed by its gear and the nearest one of the scan is kept. The point
// flagged last closes the scan and yields one result word (pop/empty) with
// the nearest point, a found flag and a proposed speed.
// Throughput: one point per cycle while the scan queue is not full.
// The last point's scan word is registered in the scan queue, then in the
// multiply stage, then in the result queue, whose head shows it.
// The multiply stage sets the back end's pace of one scan per cycle while the result queue has room.
// When pop is held low the result queue fills, then the scan queue, and
// full rises; points inside a scan are still taken while the queue has room.
// Registers are written through csr_we/csr_index/csr_wdata; the user writes them only while idle (not enforced).
// Synchronous reset restores the register defaults, empties both queues and
// clears the scan in progress.
// ----------------------------------------------------------------------------
`include "nearest_obstacle_speed_limiter_unit_macros.svh"

module nearest_obstacle_speed_limiter_unit #(
   parameter int MAX_RANGE_MM = nosl_pkg::MAX_RANGE_MM_DEF,
   parameter int SCAN_Q_DEPTH = nosl_pkg::SCAN_Q_DEPTH_DEF,
   parameter int RSP_Q_DEPTH  = nosl_pkg::RSP_Q_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [nosl_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [nosl_pkg::COORD_W-1:0]   req_point_y,
   input  logic                                  req_gear,
   input  logic                                  req_last_point,
   output logic                                  empty,
   input  logic                                  pop,
   output logic signed [nosl_pkg::COORD_W-1:0]   rsp_nearest_x,
   output logic signed [nosl_pkg::COORD_W-1:0]   rsp_nearest_y,
   output logic                                  rsp_obstacle_found,
   output logic signed [nosl_pkg::SPEED_W-1:0]   rsp_speed_out,
   input  logic                                  csr_we,
   input  logic [nosl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nosl_pkg::CSR_W-1:0]            csr_wdata
);
   import nosl_pkg::*;

   localparam int SCAN_W = $bits(nosl_scan_type);
   localparam int RSP_W  = $bits(nosl_rsp_type);

   nosl_cfg_type          cfg_ff;
   logic                  req_accept;
   logic                  scan_push, scan_pop, scan_full, scan_empty;
   nosl_scan_type         scan_in_data, scan_head;
   logic [SCAN_W-1:0]     scan_head_bits;
   logic                  rsp_push, rsp_full;
   nosl_rsp_type          rsp_in_data, rsp_head;
   logic [RSP_W-1:0]      rsp_head_bits;
   nosl_front_status_type front_status;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fwd_min_x     <= RST_WIN_MIN_X;
         cfg_ff.fwd_max_x     <= RST_WIN_MAX_X;
         cfg_ff.rev_min_x     <= RST_WIN_MIN_X;
         cfg_ff.rev_max_x     <= RST_WIN_MAX_X;
         cfg_ff.car_buffer_mm <= RST_CAR_BUFFER;
         cfg_ff.fwd_gain      <= '0;
         cfg_ff.rev_gain      <= '0;
         cfg_ff.cruise_speed  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FWD_MIN_X:  cfg_ff.fwd_min_x     <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_FWD_MAX_X:  cfg_ff.fwd_max_x     <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_REV_MIN_X:  cfg_ff.rev_min_x     <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_REV_MAX_X:  cfg_ff.rev_max_x     <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_CAR_BUFFER: cfg_ff.car_buffer_mm <= csr_wdata[BUF_W-1:0];
            CSR_FWD_GAIN:   cfg_ff.fwd_gain      <= csr_wdata[GAIN_W-1:0];
            CSR_REV_GAIN:   cfg_ff.rev_gain      <= csr_wdata[GAIN_W-1:0];
            CSR_CRUISE:     cfg_ff.cruise_speed  <= csr_wdata[BUF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input handshake: points are taken while the scan queue has room.
   assign full       = scan_full;
   assign req_accept = push && !scan_full;

   nosl_front #(
      .MAX_RANGE_MM (MAX_RANGE_MM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .gear       (req_gear),
      .last_point (req_last_point),
      .cfg        (cfg_ff),
      .scan_push  (scan_push),
      .scan_data  (scan_in_data),
      .status     (front_status)
   );

   // Queue of closed scans between the front and the back.
   nosl_fifo #(
      .WIDTH (SCAN_W),
      .DEPTH (SCAN_Q_DEPTH)
   ) u_scan_q (
      .clock     (clock),
      .reset     (reset),
      .push      (scan_push),
      .push_data (scan_in_data),
      .full      (scan_full),
      .pop       (scan_pop),
      .head_data (scan_head_bits),
      .empty     (scan_empty)
   );

   assign scan_head = scan_head_bits;

   nosl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .scan_valid (!scan_empty),
      .scan_data  (scan_head),
      .scan_pop   (scan_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in_data)
   );

   // Result queue; its head drives the result ports.
   nosl_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_Q_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .pop       (pop),
      .head_data (rsp_head_bits),
      .empty     (empty)
   );

   assign rsp_head           = rsp_head_bits;
   assign rsp_nearest_x      = rsp_head.nearest_x;
   assign rsp_nearest_y      = rsp_head.nearest_y;
   assign rsp_obstacle_found = rsp_head.found;
   assign rsp_speed_out      = rsp_head.speed;

   // A closed scan always starts the next one with nothing kept.
   `NOSL_ASSERT_NEXT(a_scan_restart, clock, reset, req_accept && req_last_point, !front_status.found)
   // Without an obstacle the reported lateral position is zero.
   `NOSL_ASSERT_SAME(a_empty_x_zero, clock, reset, !empty && !rsp_obstacle_found, rsp_nearest_x == '0)
   // A reported obstacle never lies inside the near dead zone.
   `NOSL_ASSERT_SAME(a_found_dist, clock, reset, !empty && rsp_obstacle_found, (rsp_nearest_y >= 16'sd100) || (rsp_nearest_y <= -16'sd100))
endmodule

// ----- src/nosl_fifo.sv -----
// ----------------------------------------------------------------------------
// Nearest obstacle speed limiter: small register queue
// First-in first-out buffer of flip-flops; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module nosl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = store_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; only occupied slots are ever read out.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ----- src/nosl_front.sv -----
// ----------------------------------------------------------------------------
// Nearest obstacle speed limiter: scan front end
// Windows each point, keeps the nearest one and closes the scan on the last.
// ----------------------------------------------------------------------------
module nosl_front #(
   parameter int MAX_RANGE_MM = nosl_pkg::MAX_RANGE_MM_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic signed [nosl_pkg::COORD_W-1:0]   point_x,
   input  logic signed [nosl_pkg::COORD_W-1:0]   point_y,
   input  logic                                  gear,
   input  logic                                  last_point,
   input  nosl_pkg::nosl_cfg_type                cfg,
   output logic                                  scan_push,
   output nosl_pkg::nosl_scan_type               scan_data,
   output nosl_pkg::nosl_front_status_type       status
);
   import nosl_pkg::*;

   localparam logic signed [COORD_W-1:0] RANGE_POS = COORD_W'(MAX_RANGE_MM);
   localparam logic signed [COORD_W-1:0] RANGE_NEG = COORD_W'(-MAX_RANGE_MM);
   localparam logic signed [COORD_W-1:0] DIST_POS  = COORD_W'(MIN_DIST_MM);
   localparam logic signed [COORD_W-1:0] DIST_NEG  = COORD_W'(-MIN_DIST_MM);

   logic signed [COORD_W-1:0] best_x_ff, best_x_in;
   logic signed [COORD_W-1:0] best_y_ff, best_y_in;
   logic                      found_ff, found_in;
   logic                      rev_ff;
   logic signed [COORD_W-1:0] cur_fwd, cur_rev;
   logic                      fwd_hit, rev_hit, hit;
   logic signed [COORD_W-1:0] upd_x, upd_y;
   logic                      upd_found;

   // Qualification of the incoming point against its own gear's window.
   always_comb begin
      cur_fwd = found_ff ? best_y_ff : RANGE_POS;
      cur_rev = found_ff ? best_y_ff : RANGE_NEG;
      fwd_hit = !gear && (point_x >= cfg.fwd_min_x) && (point_x <= cfg.fwd_max_x) &&
                (point_y >= DIST_POS) && (point_y < cur_fwd);
      rev_hit = gear && (point_x >= cfg.rev_min_x) && (point_x <= cfg.rev_max_x) &&
                (point_y <= DIST_NEG) && (point_y > cur_rev);
      hit       = fwd_hit || rev_hit;
      upd_x     = hit ? point_x : best_x_ff;
      upd_y     = hit ? point_y : best_y_ff;
      upd_found = hit || found_ff;
   end

   // Scan summary formed from the state after this point.
   always_comb begin
      scan_push           = accept && last_point;
      scan_data.found     = upd_found;
      scan_data.rev       = gear;
      scan_data.nearest_x = upd_found ? upd_x : '0;
      scan_data.nearest_y = upd_found ? upd_y : (gear ? RANGE_NEG : RANGE_POS);
   end

   // Next state: the last point of a scan restarts the search.
   always_comb begin
      best_x_in = best_x_ff;
      best_y_in = best_y_ff;
      found_in  = found_ff;
      if (accept) begin
         if (last_point) begin
            best_x_in = '0;
            best_y_in = RANGE_POS;
            found_in  = 1'b0;
         end else begin
            best_x_in = upd_x;
            best_y_in = upd_y;
            found_in  = upd_found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_x_ff <= '0;
         best_y_ff <= RANGE_POS;
         found_ff  <= 1'b0;
         rev_ff    <= 1'b0;
      end else begin
         best_x_ff <= best_x_in;
         best_y_ff <= best_y_in;
         found_ff  <= found_in;
         if (accept) begin
            rev_ff <= gear;
         end
      end
   end

   assign status.found = found_ff;
   assign status.rev   = rev_ff;
endmodule

// ----- src/nosl_back.sv -----
// ----------------------------------------------------------------------------
// Nearest obstacle speed limiter: speed back end
// Scales the obstacle distance by the gain, rounds and saturates the speed; a forward scan with none found gets cruise.
// ----------------------------------------------------------------------------
module nosl_back (
   input  logic                     clock,
   input  logic                     reset,
   input  nosl_pkg::nosl_cfg_type   cfg,
   input  logic                     scan_valid,
   input  nosl_pkg::nosl_scan_type  scan_data,
   output logic                     scan_pop,
   input  logic                     rsp_full,
   output logic                     rsp_push,
   output nosl_pkg::nosl_rsp_type   rsp_data
);
   import nosl_pkg::*;

   localparam int DW    = COORD_W + 2;
   localparam int MW    = DW - 1;
   localparam int PW    = MW + GAIN_W;
   localparam int RW    = PW + 1 - 16;
   localparam logic [RW-1:0] SAT_LIM = RW'(32768);

   logic signed [DW-1:0] ny_ext, buf_ext, gap;
   logic [MW-1:0]        mag;
   logic [GAIN_W-1:0]    gain;
   logic [PW-1:0]        prod;
   logic                 neg;

   logic                 a_valid_ff, a_valid_in;
   logic [PW-1:0]        prod_ff;
   logic                 neg_ff;
   logic                 cruise_ff;
   nosl_scan_type        scan_ff;
   logic                 a_ready;

   logic [PW:0]          round_sum;
   logic [RW-1:0]        rounded;
   logic signed [SPEED_W-1:0] speed;

   // Signed distance to the obstacle beyond the safety buffer, then its product.
   always_comb begin
      ny_ext  = DW'(scan_data.nearest_y);
      buf_ext = $signed({3'b000, cfg.car_buffer_mm});
      if (scan_data.rev) begin
         gap  = -(ny_ext + buf_ext);
         gain = cfg.rev_gain;
      end else begin
         gap  = ny_ext - buf_ext;
         gain = cfg.fwd_gain;
      end
      neg  = gap[DW-1];
      mag  = neg ? MW'(-gap) : MW'(gap);
      prod = PW'(mag) * PW'(gain);
   end

   // Multiply stage advances whenever the result queue has room.
   assign a_ready    = !a_valid_ff || !rsp_full;
   assign scan_pop   = scan_valid && a_ready;
   assign a_valid_in = a_ready ? scan_valid : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_pop) begin
         prod_ff   <= prod;
         neg_ff    <= neg;
         cruise_ff <= !scan_data.rev && !scan_data.found;
         scan_ff   <= scan_data;
      end
   end

   // Round halves away from zero, then saturate to 16 bits.
   always_comb begin
      round_sum = {1'b0, prod_ff} + (PW+1)'(32'h8000);
      rounded   = round_sum[PW:16];
      if (cruise_ff) begin
         speed = $signed({1'b0, cfg.cruise_speed});
      end else if (neg_ff) begin
         speed = (rounded >= SAT_LIM) ? -16'sd32768 : $signed(-rounded[SPEED_W-1:0]);
      end else begin
         speed = (rounded >= SAT_LIM) ? 16'sd32767 : $signed(rounded[SPEED_W-1:0]);
      end
   end

   assign rsp_push           = a_valid_ff && !rsp_full;
   assign rsp_data.nearest_x = scan_ff.nearest_x;
   assign rsp_data.nearest_y = scan_ff.nearest_y;
   assign rsp_data.found     = scan_ff.found;
   assign rsp_data.speed     = speed;
endmodule
